// ===== hdl/bcdec_pkg.sv =====
// Shared types and codes for the BC1/BC2/BC3 block decoder.
// Holds the input and output beat structs, the palette bundle and the format codes.
// No dependencies.
`default_nettype none

package bcdec_pkg;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;

	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;
	localparam logic [1:0] FMT_DXT5 = 2'd2;

	localparam logic [CfgAddrW-1:0] ADDR_BLOCK_FORMAT = 3'd0;

	typedef struct packed {
		logic [63:0] color_block;
		logic [63:0] alpha_block;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  row_index;
		logic [31:0] texel_col0;
		logic [31:0] texel_col1;
		logic [31:0] texel_col2;
		logic [31:0] texel_col3;
		logic        last_row;
	} out_beat_t;

	// Four color entries with their DXT1 alpha, plus the eight DXT5 alpha levels.
	typedef struct packed {
		logic [3:0][7:0] r;
		logic [3:0][7:0] g;
		logic [3:0][7:0] b;
		logic [3:0][7:0] a;
		logic [7:0][7:0] apal;
	} pal_t;

endpackage

`default_nettype wire

// ===== hdl/bcdec_palette.sv =====
// Palette builder: expands the two RGB565 endpoints and the two alpha endpoints
// into the full color and alpha palettes. Pure combinational logic.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_palette (
	input  wire logic [31:0]     endpoints,
	input  wire logic [15:0]     alpha_ends,
	output bcdec_pkg::pal_t      pal
);
	import bcdec_pkg::*;

	// Constant divisions are done as multiply by a scaled reciprocal and shift.
	// Each scale is chosen so that truncation is exact over the operand range.
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [20:0] p;
		p = 21'(x) * 21'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'd1639;
		return p[20:13];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd2341;
		return p[21:14];
	endfunction

	logic [15:0]     c0, c1;
	logic [7:0]      a0, a1;
	logic [1:0][7:0] re, ge, be;

	assign c0 = endpoints[15:0];
	assign c1 = endpoints[31:16];
	assign a0 = alpha_ends[7:0];
	assign a1 = alpha_ends[15:8];

	assign re[0] = {c0[15:11], c0[15:13]};
	assign ge[0] = {c0[10:5], c0[10:9]};
	assign be[0] = {c0[4:0], c0[4:2]};
	assign re[1] = {c1[15:11], c1[15:13]};
	assign ge[1] = {c1[10:5], c1[10:9]};
	assign be[1] = {c1[4:0], c1[4:2]};

	always_comb begin
		logic [8:0]  half_r, half_g, half_b;
		logic [10:0] sum7;
		logic [10:0] sum5;
		sum7 = '0;
		sum5 = '0;
		pal.r[0] = re[0];
		pal.g[0] = ge[0];
		pal.b[0] = be[0];
		pal.r[1] = re[1];
		pal.g[1] = ge[1];
		pal.b[1] = be[1];
		pal.a    = {4{8'hFF}};
		half_r = 9'(re[0]) + 9'(re[1]);
		half_g = 9'(ge[0]) + 9'(ge[1]);
		half_b = 9'(be[0]) + 9'(be[1]);
		// The raw 16-bit endpoint compare picks four opaque colors or three plus black.
		if (c0 > c1) begin
			pal.r[2] = div3({1'b0, re[0], 1'b0} + 10'(re[1]));
			pal.g[2] = div3({1'b0, ge[0], 1'b0} + 10'(ge[1]));
			pal.b[2] = div3({1'b0, be[0], 1'b0} + 10'(be[1]));
			pal.r[3] = div3(10'(re[0]) + {1'b0, re[1], 1'b0});
			pal.g[3] = div3(10'(ge[0]) + {1'b0, ge[1], 1'b0});
			pal.b[3] = div3(10'(be[0]) + {1'b0, be[1], 1'b0});
		end else begin
			pal.r[2] = half_r[8:1];
			pal.g[2] = half_g[8:1];
			pal.b[2] = half_b[8:1];
			pal.r[3] = 8'd0;
			pal.g[3] = 8'd0;
			pal.b[3] = 8'd0;
			pal.a[3] = 8'd0;
		end

		pal.apal[0] = a0;
		pal.apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 2; i < 8; i++) begin
				sum7 = 11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
				pal.apal[i] = div7(sum7);
			end
		end else begin
			for (int i = 2; i < 6; i++) begin
				sum5 = 11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
				pal.apal[i] = div5(sum5);
			end
			pal.apal[6] = 8'd0;
			pal.apal[7] = 8'hFF;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bc1_bc2_bc3_block_decoder_unit.sv =====
// Top level of the BC1/BC2/BC3 block decoder: input register, palette stage,
// row sequencer, output register and the format register on an APB-style port.
// Depends on bcdec_pkg and bcdec_palette.
//
// Usage:
// One input beat carries a whole compressed 4x4 block (color half and alpha half).
// Each block yields four output beats, rows 0 to 3 in order, each with four RGBA8
// texels; last_row marks the fourth. The block_format register (byte address 0)
// selects DXT1, DXT3 or DXT5; code 3 decodes as DXT1. Write it only while idle.
// The first row goes from the input register through the palette stage to the
// output register; the other rows follow back to back when the receiver does not
// stall. The block rate is set by the output channel carrying one row per beat.
// The next block is taken into the input register while the current one is still
// being sent, so back-to-back blocks leave no gaps.
// When the receiver stalls, the output beat holds, the row sequencer waits and,
// once the input register is full, in_stall rises.
// Reset clears all valid flags and sets block_format to DXT1; pready is always high.
`default_nettype none

module bc1_bc2_bc3_block_decoder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire bcdec_pkg::in_beat_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output bcdec_pkg::out_beat_t               out_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcdec_pkg::CfgAddrW-1:0] paddr,
	input  wire logic [bcdec_pkg::CfgDataW-1:0] pwdata,
	output logic [bcdec_pkg::CfgDataW-1:0]     prdata,
	output logic                               pready
);
	import bcdec_pkg::*;

	logic [1:0]  fmt_q;

	in_beat_t    blk_s1;
	logic        vld_s1;

	pal_t        pal_s2;
	pal_t        pal_c;
	logic [31:0] cidx_s2;
	logic [63:0] ab_s2;
	logic        vld_s2;
	logic [1:0]  row_s2;

	out_beat_t   out_q;
	logic        out_vld_q;

	logic        out_load, s2_free, s1_move, in_acc, cfg_wr;
	logic [7:0]  cidx_row;
	logic [15:0] a4_row;
	logic [11:0] a3_row;
	logic [5:0]  a3_base;
	logic [3:0][31:0] texel;

	assign pready = 1'b1;
	assign prdata = {{(CfgDataW-2){1'b0}}, fmt_q};
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_BLOCK_FORMAT[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_DXT1;
		end else if (cfg_wr) begin
			fmt_q <= pwdata[1:0];
		end
	end

	// Handshake chain: the output register pulls rows, the last row frees stage 2.
	assign out_load = vld_s2 && (!out_vld_q || !out_stall);
	assign s2_free  = !vld_s2 || (out_load && row_s2 == 2'd3);
	assign s1_move  = vld_s1 && s2_free;
	assign in_stall = vld_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	bcdec_palette u_pal (
		.endpoints  (blk_s1.color_block[31:0]),
		.alpha_ends (blk_s1.alpha_block[15:0]),
		.pal        (pal_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			row_s2 <= 2'd0;
		end else if (s1_move) begin
			vld_s2 <= 1'b1;
			row_s2 <= 2'd0;
		end else if (s2_free) begin
			vld_s2 <= 1'b0;
		end else if (out_load) begin
			row_s2 <= row_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			pal_s2  <= pal_c;
			cidx_s2 <= blk_s1.color_block[63:32];
			ab_s2   <= blk_s1.alpha_block;
		end
	end

	// Row slices of the index fields for the row being sent.
	assign a3_base  = 6'd16 + 6'(row_s2) * 6'd12;
	assign cidx_row = cidx_s2[{row_s2, 3'b000} +: 8];
	assign a4_row   = ab_s2[{row_s2, 4'b0000} +: 16];
	assign a3_row   = ab_s2[a3_base +: 12];

	always_comb begin
		logic [1:0] ci;
		logic [3:0] n4;
		logic [2:0] ai;
		logic [7:0] alpha;
		for (int x = 0; x < 4; x++) begin
			ci = cidx_row[2*x +: 2];
			n4 = a4_row[4*x +: 4];
			ai = a3_row[3*x +: 3];
			case (fmt_q)
				FMT_DXT3: alpha = {n4, n4};
				FMT_DXT5: alpha = pal_s2.apal[ai];
				default:  alpha = pal_s2.a[ci];
			endcase
			texel[x] = {alpha, pal_s2.b[ci], pal_s2.g[ci], pal_s2.r[ci]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.row_index  <= row_s2;
			out_q.texel_col0 <= texel[0];
			out_q.texel_col1 <= texel[1];
			out_q.texel_col2 <= texel[2];
			out_q.texel_col3 <= texel[3];
			out_q.last_row   <= (row_s2 == 2'd3);
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hdl/bcdec_checker.sv =====
// Port-level checker for the BC1/BC2/BC3 block decoder, bound to the top level.
// Watches row ordering, output hold under stall and the format register.
// Depends on bcdec_pkg.
`default_nettype none

module bcdec_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire bcdec_pkg::out_beat_t           out_data,
	input wire logic                           psel,
	input wire logic                           penable,
	input wire logic                           pwrite,
	input wire logic [bcdec_pkg::CfgAddrW-1:0] paddr,
	input wire logic [bcdec_pkg::CfgDataW-1:0] pwdata,
	input wire logic [bcdec_pkg::CfgDataW-1:0] prdata
);
	import bcdec_pkg::*;

	// A stalled output beat stays up and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// The last-row flag marks row three and nothing else.
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_row == (out_data.row_index == 2'd3)))
		else $error("last_row does not match row_index");

	// Rows of one block leave back to back and in order.
	a_row_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_row |=>
			out_valid && (out_data.row_index == 2'($past(out_data.row_index) + 2'd1)))
		else $error("row sequence broken inside a block");

	// A write to the format register is read back.
	a_cfg_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == ADDR_BLOCK_FORMAT[2]) |=>
			prdata[1:0] == $past(pwdata[1:0]))
		else $error("format register readback mismatch");

endmodule

bind bc1_bc2_bc3_block_decoder_unit bcdec_checker u_bcdec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

`default_nettype wire
